// ===== hw/rtl/mmad_pkg.sv =====
package mmad_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int CHAN_BITS    = 3;
    localparam int THRESH_BITS  = 10;
    localparam int CHANNELS_DEF = 5;
    localparam int WINDOW_DEF   = 8;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(2);

    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_PRIME  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

    typedef struct packed
    {
        kind_t                  kind;
        logic [CHAN_BITS-1:0]   channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   end_of_scan;
    } item_t;

    typedef struct packed
    {
        logic [CHAN_BITS-1:0]   out_channel;
        logic [SAMPLE_BITS-1:0] average;
        logic [SAMPLE_BITS-1:0] reported;
        logic                   changed;
    } result_t;

endpackage

// ===== hw/rtl/mmad_ram.sv =====
module mmad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/mmad_alu.sv =====
module mmad_alu #(
    parameter int WIDTH = 16
) (
    input  mmad_pkg::alu_op_t  op,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [2*WIDTH-1:0] res
);
    import mmad_pkg::*;

    logic [WIDTH-1:0] sum;
    logic [WIDTH-1:0] diff;

    assign sum  = a + b;
    assign diff = a - b;

    always_comb
    begin
        case (op)
            ALU_ADD: res = {{WIDTH{1'b0}}, sum};
            ALU_SUB: res = {{WIDTH{1'b0}}, diff};
            ALU_MUL: res = a * b;
            default: res = '0;
        endcase
    end

endmodule

// ===== hw/rtl/multichannel_moving_average_deadband.sv =====
// Multichannel moving average with dead band.
// Input channel: sample_valid / sample_stall / sample_item. A transfer takes place
// when sample_valid is high and sample_stall is low. A prime item fills the
// channel's window with its sample; a sample item replaces the oldest window
// entry, and the reported value follows the window average only when the
// average lies strictly outside reported +/- the threshold.
// Result channel: result_valid / result_stall / result_item, one result per item.
// A sample item steps through S_SUB, S_ADD, S_RECIP, S_MULW, S_FIX, S_BAND,
// S_DECIDE and S_DONE. A prime item goes through S_PRIME, then S_FILL once per
// window entry, as the history RAM has a single write port, and then S_DONE.
// An item for a channel outside the configured range goes straight to S_DONE.
// The sample item steps share one add/subtract/multiply unit that a sequencer
// steps through the total update, the reciprocal divide and the dead band
// compare. sample_stall is high while an item is in work.
// The result sits in an output register; a new item is taken while it waits,
// and only the final step of the next item waits on result_stall.
// Reset clears the running totals, reported values and window position and sets
// the threshold (cfg_we / cfg_wdata) to 2. Window history is not cleared:
// prime every channel before sending it sample items.
module multichannel_moving_average_deadband #(
    parameter int CHANNELS = mmad_pkg::CHANNELS_DEF,
    parameter int WINDOW   = mmad_pkg::WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mmad_pkg::THRESH_BITS-1:0] cfg_wdata,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  mmad_pkg::item_t                  sample_item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output mmad_pkg::result_t                result_item
);
    import mmad_pkg::*;

    localparam int POS_BITS    = $clog2(WINDOW);
    localparam int WPAD        = 2 ** POS_BITS;
    localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAM_DEPTH   = CHANNELS * WPAD;
    localparam int ADDR_W      = $clog2(RAM_DEPTH);
    localparam int TOTAL_W     = SAMPLE_BITS + POS_BITS;
    localparam int ALU_W       = TOTAL_W + 1;
    localparam int RECIP       = (2 ** TOTAL_W) / WINDOW;
    localparam int CMP_W       = (ALU_W > THRESH_BITS) ? ALU_W : THRESH_BITS;

    localparam logic [4:0]          CH_LIMIT = 5'(CHANNELS);
    localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(WINDOW - 1);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SUB,
        S_ADD,
        S_RECIP,
        S_MULW,
        S_FIX,
        S_BAND,
        S_DECIDE,
        S_PRIME,
        S_FILL,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [POS_BITS-1:0]      pos_reg, pos_next;
    logic [POS_BITS-1:0]      fill_reg, fill_next;
    logic [THRESH_BITS-1:0]   thr_reg, thr_next;
    logic [TOTAL_W-1:0]       total_reg [CHANNELS];
    logic [TOTAL_W-1:0]       total_next [CHANNELS];
    logic [SAMPLE_BITS-1:0]   held_reg [CHANNELS];
    logic [SAMPLE_BITS-1:0]   held_next [CHANNELS];
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;

    item_t                    item_reg, item_next;
    logic                     in_range_reg, in_range_next;
    logic [ALU_W-1:0]         acc_reg, acc_next;
    logic [2*ALU_W-1:0]       prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0]   avg_reg, avg_next;
    logic                     chg_reg, chg_next;

    logic                     accept;
    logic [CH_IDX_BITS-1:0]   ch_idx;
    logic [SAMPLE_BITS-1:0]   q_est;
    logic [ALU_W-1:0]         abs_diff;

    alu_op_t                  alu_op;
    logic [ALU_W-1:0]         alu_a;
    logic [ALU_W-1:0]         alu_b;
    logic [2*ALU_W-1:0]       alu_res;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [SAMPLE_BITS-1:0]   ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [SAMPLE_BITS-1:0]   ram_rdata;

    mmad_alu #(
        .WIDTH (ALU_W)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    mmad_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    assign ch_idx   = CH_IDX_BITS'(item_reg.channel);
    assign q_est    = prod_reg[TOTAL_W +: SAMPLE_BITS];
    assign abs_diff = acc_reg[ALU_W-1] ? (-acc_reg) : acc_reg;

    // The oldest entry is read at the transfer edge so that it is ready in the
    // first step of the item.
    assign ram_raddr = ADDR_W'({CH_IDX_BITS'(sample_item.channel), pos_reg});
    assign ram_wdata = item_reg.sample;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        thr_next       = cfg_we ? cfg_wdata : thr_reg;
        total_next     = total_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        item_next      = item_reg;
        in_range_next  = in_range_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        avg_next       = avg_reg;
        chg_next       = chg_reg;
        alu_op         = ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'({ch_idx, pos_reg});

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next     = sample_item;
                    in_range_next = ({2'b00, sample_item.channel} < CH_LIMIT);
                    if (!({2'b00, sample_item.channel} < CH_LIMIT))
                    begin
                        state_next = S_DONE;
                    end
                    else if (sample_item.kind == KIND_PRIME)
                    begin
                        state_next = S_PRIME;
                    end
                    else
                    begin
                        state_next = S_SUB;
                    end
                end
            end
            S_SUB:
            begin
                alu_op     = ALU_SUB;
                alu_a      = ALU_W'(total_reg[ch_idx]);
                alu_b      = ALU_W'(ram_rdata);
                acc_next   = alu_res[ALU_W-1:0];
                ram_we     = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                alu_op             = ALU_ADD;
                alu_a              = acc_reg;
                alu_b              = ALU_W'(item_reg.sample);
                acc_next           = {1'b0, alu_res[TOTAL_W-1:0]};
                total_next[ch_idx] = alu_res[TOTAL_W-1:0];
                state_next         = S_RECIP;
            end
            S_RECIP:
            begin
                // The scaled reciprocal gives the quotient or one less.
                alu_op     = ALU_MUL;
                alu_a      = acc_reg;
                alu_b      = ALU_W'(RECIP);
                prod_next  = alu_res;
                state_next = S_MULW;
            end
            S_MULW:
            begin
                alu_op     = ALU_MUL;
                alu_a      = ALU_W'(q_est);
                alu_b      = ALU_W'(WINDOW);
                prod_next  = alu_res;
                avg_next   = q_est;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = prod_reg[ALU_W-1:0];
                if (alu_res[ALU_W-1:0] >= ALU_W'(WINDOW))
                begin
                    avg_next = avg_reg + SAMPLE_BITS'(1);
                end
                state_next = S_BAND;
            end
            S_BAND:
            begin
                alu_op     = ALU_SUB;
                alu_a      = ALU_W'(avg_reg);
                alu_b      = ALU_W'(held_reg[ch_idx]);
                acc_next   = alu_res[ALU_W-1:0];
                chg_next   = 1'b0;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (CMP_W'(abs_diff) > CMP_W'(thr_reg))
                begin
                    held_next[ch_idx] = avg_reg;
                    chg_next          = 1'b1;
                end
                state_next = S_DONE;
            end
            S_PRIME:
            begin
                alu_op             = ALU_MUL;
                alu_a              = ALU_W'(item_reg.sample);
                alu_b              = ALU_W'(WINDOW);
                total_next[ch_idx] = alu_res[TOTAL_W-1:0];
                held_next[ch_idx]  = item_reg.sample;
                avg_next           = item_reg.sample;
                chg_next           = 1'b1;
                fill_next          = '0;
                state_next         = S_FILL;
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'({ch_idx, fill_reg});
                if (fill_reg == POS_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    fill_next = fill_reg + POS_BITS'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.out_channel = item_reg.channel;
                    if (in_range_reg)
                    begin
                        out_next.average  = avg_reg;
                        out_next.reported = held_reg[ch_idx];
                        out_next.changed  = chg_reg;
                    end
                    else
                    begin
                        out_next.average  = '0;
                        out_next.reported = '0;
                        out_next.changed  = 1'b0;
                    end
                    if (item_reg.end_of_scan)
                    begin
                        pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_BITS'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            fill_reg      <= '0;
            thr_reg       <= THRESH_RESET;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                total_reg[i] <= '0;
                held_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            total_reg     <= total_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        in_range_reg <= in_range_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        avg_reg      <= avg_next;
        chg_reg      <= chg_next;
    end

endmodule

// ===== hw/rtl/mmad_checker.sv =====
module mmad_checker #(
    parameter int CHANNELS = mmad_pkg::CHANNELS_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input logic              result_valid,
    input logic              result_stall,
    input mmad_pkg::result_t result_item
);
    import mmad_pkg::*;

    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

    // A transfer always raises sample_stall, since the item goes into work.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
    else $error("sample channel ready right after a transfer");

    // A new result only ever follows a cycle in which an item was in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
    else $error("result appeared with no item in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result_item)))
    else $error("stalled result dropped or changed");

    // Whenever the reported value moves, it moves onto the average.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.changed) |->
            (result_item.average == result_item.reported))
    else $error("changed result with reported value off the average");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ({2'b00, result_item.out_channel} >= CH_LIMIT)) |->
            (!result_item.changed && result_item.average == '0 &&
             result_item.reported == '0))
    else $error("result for an unused channel carries data");

endmodule

bind multichannel_moving_average_deadband mmad_checker #(
    .CHANNELS (CHANNELS)
) u_mmad_checker (.*);

// ===== tb/multichannel_moving_average_deadband_tb.sv =====
`timescale 1ns / 100ps

module multichannel_moving_average_deadband_tb;

    import mmad_pkg::*;

    localparam int CHANNELS    = CHANNELS_DEF;
    localparam int WINDOW      = WINDOW_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_SAMPLE  = (1 << SAMPLE_BITS) - 1;
    localparam int MAX_THRESH  = (1 << THRESH_BITS) - 1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [THRESH_BITS-1:0] cfg_wdata;
    logic                   sample_valid;
    logic                   sample_stall;
    item_t                  sample_item;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result_item;

    // Shadow copy of the filter state.
    logic [SAMPLE_BITS-1:0] window_mem [CHANNELS][WINDOW];
    int unsigned            chan_total [CHANNELS];
    int unsigned            chan_held [CHANNELS];
    bit                     chan_primed [CHANNELS];
    int unsigned            win_pos;
    int unsigned            deadband;

    result_t pending_results[$];
    int      mismatch_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;

    multichannel_moving_average_deadband u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic result_t filter_predict(item_t it);
        result_t     r;
        int unsigned avg;
        int          lo;
        int          hi;
        r = '0;
        r.out_channel = it.channel;
        if (it.channel < CHANNELS)
        begin
            if (it.kind == KIND_PRIME)
            begin
                for (int i = 0; i < WINDOW; i++)
                    window_mem[it.channel][i] = it.sample;
                chan_total[it.channel] = it.sample * WINDOW;
                chan_held[it.channel] = 32'(it.sample);
                chan_primed[it.channel] = 1'b1;
                r.average = it.sample;
                r.changed = 1'b1;
            end
            else
            begin
                chan_total[it.channel] = chan_total[it.channel]
                                         - window_mem[it.channel][win_pos] + it.sample;
                window_mem[it.channel][win_pos] = it.sample;
                avg = chan_total[it.channel] / WINDOW;
                lo = int'(chan_held[it.channel]) - int'(deadband);
                hi = int'(chan_held[it.channel]) + int'(deadband);
                if (int'(avg) < lo || int'(avg) > hi)
                begin
                    chan_held[it.channel] = avg;
                    r.changed = 1'b1;
                end
                r.average = SAMPLE_BITS'(avg);
            end
            r.reported = SAMPLE_BITS'(chan_held[it.channel]);
        end
        if (it.end_of_scan)
            win_pos = (win_pos + 1) % WINDOW;
        return r;
    endfunction

    // Offers one item, with random idle cycles in front of it, and records the
    // expected result once the transfer takes place. Returns just after that edge.
    task automatic push_sample(input kind_t kind, input int chan, input int smp,
                               input bit eos);
        item_t it;
        it.kind = kind;
        it.channel = chan[CHAN_BITS-1:0];
        it.sample = smp[SAMPLE_BITS-1:0];
        it.end_of_scan = eos;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_item <= it;
        do
            @(posedge clk);
        while (sample_stall);
        pending_results.push_back(filter_predict(it));
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input int value);
        wait_all_results();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[THRESH_BITS-1:0];
        deadband = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly in-range channels with samples near the held value, so that the
    // dead band is hit from both sides; the rest is full-range noise.
    task automatic push_random_sample();
        int    chan;
        int    smp;
        kind_t kind;
        bit    eos;
        chan = ($urandom_range(0, 99) < 8) ? $urandom_range(CHANNELS, 7)
                                            : $urandom_range(0, CHANNELS - 1);
        kind = ($urandom_range(0, 99) < 6) ? KIND_PRIME : KIND_SAMPLE;
        if (chan < CHANNELS && !chan_primed[chan])
            kind = KIND_PRIME;
        if (chan < CHANNELS && $urandom_range(0, 1) == 0)
        begin
            smp = int'(chan_held[chan]) + $urandom_range(0, 48) - 24;
            if (smp < 0)
                smp = 0;
            if (smp > MAX_SAMPLE)
                smp = MAX_SAMPLE;
        end
        else
            smp = $urandom_range(0, MAX_SAMPLE);
        eos = ($urandom_range(0, 3) == 0);
        push_sample(kind, chan, smp, eos);
    endtask

    task automatic run_random(input int count);
        repeat (count) push_random_sample();
    endtask

    task automatic test_prime_extremes();
        push_sample(KIND_PRIME, 0, 0, 1'b0);
        push_sample(KIND_PRIME, 1, MAX_SAMPLE, 1'b0);
        push_sample(KIND_PRIME, 2, 512, 1'b0);
        push_sample(KIND_PRIME, 3, 1, 1'b0);
        push_sample(KIND_PRIME, 4, MAX_SAMPLE - 1, 1'b1);
    endtask

    task automatic test_channel_out_of_range();
        push_sample(KIND_SAMPLE, 5, MAX_SAMPLE, 1'b1);
        push_sample(KIND_PRIME, 6, 0, 1'b0);
        push_sample(KIND_SAMPLE, 7, MAX_SAMPLE, 1'b0);
    endtask

    task automatic test_deadband_edges();
        // Averages that land on the band edge and just past it, on both sides.
        push_sample(KIND_SAMPLE, 2, 528, 1'b1);
        push_sample(KIND_SAMPLE, 2, 536, 1'b0);
        push_sample(KIND_SAMPLE, 4, MAX_SAMPLE - 17, 1'b1);
        push_sample(KIND_SAMPLE, 4, MAX_SAMPLE - 40, 1'b0);
        push_sample(KIND_SAMPLE, 1, 0, 1'b0);
        push_sample(KIND_SAMPLE, 0, MAX_SAMPLE, 1'b1);
    endtask

    task automatic test_position_wrap();
        for (int i = 0; i < WINDOW + 1; i++)
            push_sample(KIND_SAMPLE, 3, (i % 2) ? MAX_SAMPLE : 0, 1'b1);
    endtask

    task automatic test_threshold_settings();
        write_threshold(0);
        run_random(150);
        write_threshold(MAX_THRESH);
        run_random(100);
        write_threshold($urandom_range(1, 12));
        run_random(150);
        write_threshold(int'(THRESH_RESET));
    endtask

    task automatic test_slow_receiver();
        send_idle_pct = 16;
        recv_stall_pct = 78;
        run_random(250);
    endtask

    task automatic test_slow_sender();
        send_idle_pct = 78;
        recv_stall_pct = 16;
        run_random(250);
    endtask

    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(250);
    endtask

    task automatic test_result_holdoff();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_all_results();
        @(posedge clk);
        hold_cycles = 300;
        run_random(40);
        wait_all_results();
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_stall <= 1'b1;
            hold_cycles--;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expected result pending");
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result_item.out_channel !== exp_r.out_channel)
                begin
                    $error("out_channel: expected %0d, actual %0d",
                           exp_r.out_channel, result_item.out_channel);
                    mismatch_count++;
                end
                if (result_item.average !== exp_r.average)
                begin
                    $error("average: expected %0d, actual %0d",
                           exp_r.average, result_item.average);
                    mismatch_count++;
                end
                if (result_item.reported !== exp_r.reported)
                begin
                    $error("reported: expected %0d, actual %0d",
                           exp_r.reported, result_item.reported);
                    mismatch_count++;
                end
                if (result_item.changed !== exp_r.changed)
                begin
                    $error("changed: expected %0d, actual %0d",
                           exp_r.changed, result_item.changed);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multichannel_moving_average_deadband_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sample_valid = 1'b0;
        sample_item = '0;
        result_stall = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        win_pos = 0;
        deadband = 32'(THRESH_RESET);
        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_total[c] = 0;
            chan_held[c] = 0;
            chan_primed[c] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 10;
        recv_stall_pct = 20;
        test_prime_extremes();
        test_channel_out_of_range();
        test_deadband_edges();
        test_position_wrap();
        test_threshold_settings();
        test_slow_receiver();
        test_slow_sender();
        test_full_rate();
        test_result_holdoff();

        wait_all_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("multichannel_moving_average_deadband_tb OK");
        else
            $display("multichannel_moving_average_deadband_tb NOT OK");
        $finish;
    end

endmodule
